FILE: sv/bsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants of the bank switch controller
// Access kinds, address regions, clock select codes and the structs that pass
// between the decoder, the state registers and the top level.
// ----------------------------------------------------------------------------
package bsc_pkg;

	// kind of result word
	typedef enum logic [2:0] {
		KIND_ROM_RD = 3'd0,
		KIND_RAM_RD = 3'd1,
		KIND_RAM_WR = 3'd2,
		KIND_DIRECT = 3'd3,
		KIND_ABSORB = 3'd4
	} acc_kind_t;

	// address regions, bus address bits 15:13
	localparam logic [2:0] REG_ENABLE   = 3'd0;
	localparam logic [2:0] REG_ROM_BANK = 3'd1;
	localparam logic [2:0] REG_RAM_SEL  = 3'd2;
	localparam logic [2:0] REG_LATCH    = 3'd3;
	localparam logic [2:0] REG_EXT_RAM  = 3'd5;

	// request type codes
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// enable key in the low nibble
	localparam logic [3:0] ENABLE_KEY = 4'hA;

	// bank select byte ranges
	localparam logic [7:0] RAM_SEL_MAX  = 8'h03;
	localparam logic [7:0] CLK_CODE_LO  = 8'h08;
	localparam logic [7:0] CLK_CODE_HI  = 8'h0C;
	localparam logic [7:0] CLK_CODE_OFS = 8'h07;

	// clock register selection: none, or 1 to 5
	localparam logic [2:0] CLK_SEL_NONE = 3'd0;
	localparam logic [2:0] CLK_SEL_MAX  = 3'd5;
	localparam int         CLK_REGS     = 5;

	// latch sequence bytes
	localparam logic [7:0] LATCH_ARM  = 8'h00;
	localparam logic [7:0] LATCH_FIRE = 8'h01;

	// byte returned while disabled or unmapped
	localparam logic [7:0] OPEN_BUS = 8'hFF;

	localparam int ADDR_W = 21;

	// one result word
	typedef struct packed {
		acc_kind_t         kind;
		logic [ADDR_W-1:0] mem_address;
		logic [7:0]        read_data;
		logic [7:0]        mem_write_data;
	} bsc_res_t;

	// register updates from the decoder
	typedef struct packed {
		logic       enable_we;
		logic       enable_d;
		logic       rom_we;
		logic       ram_we;
		logic       clksel_we;
		logic [2:0] clksel_d;
		logic       clkreg_we;
		logic       latch_we;
		logic       latch_toggle;
		logic [7:0] wdata;
	} bsc_upd_t;

endpackage
`default_nettype wire

FILE: sv/bsc_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_decode: bus access decoder
// Maps one registered bus access and the current controller state to a result
// word and the register updates that the access causes.
// ----------------------------------------------------------------------------
module bsc_decode #(
	parameter int ROM_BANK_BITS = 7,
	parameter int RAM_BANK_BITS = 2
) (
	input  wire logic                     req_type,
	input  wire logic [15:0]              address,
	input  wire logic [7:0]               write_data,
	input  wire logic [6:0]               rom_bank_mask,
	input  wire logic                     enabled,
	input  wire logic [ROM_BANK_BITS-1:0] rom_bank,
	input  wire logic [RAM_BANK_BITS-1:0] ram_bank,
	input  wire logic [2:0]               clock_select,
	input  wire logic [7:0]               clk_rd_byte,
	input  wire logic [7:0]               last_latch_byte,
	output bsc_pkg::bsc_res_t             res,
	output bsc_pkg::bsc_upd_t             upd,
	output logic [ROM_BANK_BITS-1:0]      rom_bank_d,
	output logic [RAM_BANK_BITS-1:0]      ram_bank_d
);
	import bsc_pkg::*;

	logic [2:0]               region;
	logic [ADDR_W-1:0]        ram_pa;
	logic [ADDR_W-1:0]        rom_pa;
	logic                     clk_sel_valid;
	logic [7:0]               mask_ext;
	logic [ROM_BANK_BITS-1:0] rom_masked;

	// address views
	assign region        = address[15:13];
	assign ram_pa        = ADDR_W'({ram_bank, address[12:0]});
	assign rom_pa        = ADDR_W'({rom_bank, address[13:0]});
	assign clk_sel_valid = (clock_select != CLK_SEL_NONE) && (clock_select <= CLK_SEL_MAX);
	assign mask_ext      = {1'b0, rom_bank_mask};
	assign rom_masked    = write_data[ROM_BANK_BITS-1:0] & mask_ext[ROM_BANK_BITS-1:0];

	// decode of one word
	always_comb begin
		res                = '{kind: KIND_ABSORB, mem_address: '0, read_data: '0,
		                       mem_write_data: '0};
		upd                = '0;
		upd.wdata          = write_data;
		rom_bank_d         = (rom_masked == '0) ? ROM_BANK_BITS'(1) : rom_masked;
		ram_bank_d         = write_data[RAM_BANK_BITS-1:0];
		if (req_type == REQ_WRITE) begin
			unique case (region)
				REG_ENABLE: begin
					upd.enable_we = 1'b1;
					upd.enable_d  = (write_data[3:0] == ENABLE_KEY);
				end
				REG_ROM_BANK: begin
					upd.rom_we = 1'b1;
				end
				REG_RAM_SEL: begin
					upd.clksel_we = 1'b1;
					if (write_data <= RAM_SEL_MAX) begin
						upd.ram_we   = 1'b1;
						upd.clksel_d = CLK_SEL_NONE;
					end else if (write_data >= CLK_CODE_LO && write_data <= CLK_CODE_HI) begin
						upd.clksel_d = 3'(write_data - CLK_CODE_OFS);
					end else begin
						upd.clksel_d = CLK_SEL_NONE;
					end
				end
				REG_LATCH: begin
					upd.latch_we     = 1'b1;
					upd.latch_toggle = (last_latch_byte == LATCH_ARM) &&
					                   (write_data == LATCH_FIRE);
				end
				REG_EXT_RAM: begin
					if (clk_sel_valid) begin
						upd.clkreg_we = 1'b1;
					end else begin
						res.kind           = KIND_RAM_WR;
						res.mem_address    = ram_pa;
						res.mem_write_data = write_data;
					end
				end
				default: begin
				end
			endcase
		end else begin
			// reads
			if (region == REG_ENABLE || region == REG_ROM_BANK) begin
				res.kind        = KIND_ROM_RD;
				res.mem_address = ADDR_W'(address);
			end else if (region == REG_RAM_SEL || region == REG_LATCH) begin
				res.kind        = KIND_ROM_RD;
				res.mem_address = rom_pa;
			end else if (region != REG_EXT_RAM || !enabled) begin
				res.kind      = KIND_DIRECT;
				res.read_data = OPEN_BUS;
			end else if (clk_sel_valid) begin
				res.kind      = KIND_DIRECT;
				res.read_data = clk_rd_byte;
			end else begin
				res.kind        = KIND_RAM_RD;
				res.mem_address = ram_pa;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/bsc_state.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_state: controller registers
// Holds the enable, bank selects, clock register file, latch state and the
// ROM bank mask, and applies the decoder's updates when a word advances.
// ----------------------------------------------------------------------------
module bsc_state #(
	parameter int ROM_BANK_BITS = 7,
	parameter int RAM_BANK_BITS = 2
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [6:0]               cfg_wdata,
	input  wire logic                     advance,
	input  wire bsc_pkg::bsc_upd_t        upd,
	input  wire logic [ROM_BANK_BITS-1:0] rom_bank_d,
	input  wire logic [RAM_BANK_BITS-1:0] ram_bank_d,
	output logic [6:0]                    rom_bank_mask,
	output logic                          enabled,
	output logic [ROM_BANK_BITS-1:0]      rom_bank,
	output logic [RAM_BANK_BITS-1:0]      ram_bank,
	output logic [2:0]                    clock_select,
	output logic [7:0]                    clk_rd_byte,
	output logic [7:0]                    last_latch_byte
);
	import bsc_pkg::*;

	logic [6:0]               mask_q;
	logic                     enabled_q;
	logic [ROM_BANK_BITS-1:0] rom_bank_q;
	logic [RAM_BANK_BITS-1:0] ram_bank_q;
	logic [2:0]               clksel_q;
	logic [7:0]               clk_regs_q [CLK_REGS];
	logic                     latched_q;
	logic [7:0]               latch_byte_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 7'h7F;
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q    <= 1'b0;
			rom_bank_q   <= ROM_BANK_BITS'(1);
			ram_bank_q   <= '0;
			clksel_q     <= CLK_SEL_NONE;
			latched_q    <= 1'b0;
			latch_byte_q <= LATCH_ARM;
		end else if (advance) begin
			if (upd.enable_we) begin
				enabled_q <= upd.enable_d;
			end
			if (upd.rom_we) begin
				rom_bank_q <= rom_bank_d;
			end
			if (upd.ram_we) begin
				ram_bank_q <= ram_bank_d;
			end
			if (upd.clksel_we) begin
				clksel_q <= upd.clksel_d;
			end
			if (upd.latch_we) begin
				latched_q    <= latched_q ^ upd.latch_toggle;
				latch_byte_q <= upd.wdata;
			end
		end
	end

	// clock register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLK_REGS; i++) begin
				clk_regs_q[i] <= '0;
			end
		end else if (advance && upd.clkreg_we) begin
			for (int i = 0; i < CLK_REGS; i++) begin
				if (clksel_q == 3'(i + 1)) begin
					clk_regs_q[i] <= upd.wdata;
				end
			end
		end
	end

	// selected clock register, zero when none selected
	always_comb begin
		clk_rd_byte = '0;
		for (int i = 0; i < CLK_REGS; i++) begin
			if (clksel_q == 3'(i + 1)) begin
				clk_rd_byte = clk_regs_q[i];
			end
		end
	end

	// latch flag is kept but drives nothing; it only toggles itself
	assign rom_bank_mask   = mask_q;
	assign enabled         = enabled_q;
	assign rom_bank        = rom_bank_q;
	assign ram_bank        = ram_bank_q;
	assign clock_select    = clksel_q;
	assign last_latch_byte = latch_byte_q;

endmodule
`default_nettype wire

FILE: sv/bank_switch_controller_rtc_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bank_switch_controller_rtc_core: cartridge bank controller with clock regs
// Input channel s_axis: one bus access per word. Output channel m_axis: one
// result word per access, in order.
//
// Each accepted access is held in an input register, decoded against the
// controller registers, and its result is placed in the output register while
// the registers take the update. The result is valid once the access has passed
// the input register and then the output register; one word is accepted every
// cycle while the output is taken every cycle.
// When the receiver stalls, the result waits in the output register and the
// next access waits in the input register; the input stops taking words only
// when both are full, and tready falls back to high as soon as space frees.
// Reset (arst_n low) clears both registers to empty and sets the controller
// to: disabled, ROM bank 1, RAM bank 0, no clock register selected, clock
// registers zero, latch state clear, ROM bank mask 7F.
// cfg_we writes the ROM bank mask; the user must write it only while no word is
// in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module bank_switch_controller_rtc_core #(
	parameter int ROM_BANK_BITS = 7,
	parameter int RAM_BANK_BITS = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: rom_bank_mask
	input  wire logic        cfg_we,
	input  wire logic [6:0]  cfg_wdata,
	// input words
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // address[15:0], write_data[23:16]
	input  wire logic        s_axis_tuser,  // req_type
	// result words
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // mem_address[20:0], read_data[28:21],
	                                        // mem_write_data[36:29], zero[39:37]
	output logic [2:0]       m_axis_tuser   // access_kind
);
	import bsc_pkg::*;

	logic                     s1_valid_q;
	logic                     req_type_s1;
	logic [15:0]              address_s1;
	logic [7:0]               write_data_s1;
	logic                     out_valid_q;
	bsc_res_t                 out_q;
	logic                     advance;
	bsc_res_t                 res;
	bsc_upd_t                 upd;
	logic [ROM_BANK_BITS-1:0] rom_bank_d;
	logic [RAM_BANK_BITS-1:0] ram_bank_d;
	logic [6:0]               rom_bank_mask;
	logic                     enabled;
	logic [ROM_BANK_BITS-1:0] rom_bank;
	logic [RAM_BANK_BITS-1:0] ram_bank;
	logic [2:0]               clock_select;
	logic [7:0]               clk_rd_byte;
	logic [7:0]               last_latch_byte;

	// handshake: a word moves on when the output register is free or drains
	assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_type_s1   <= s_axis_tuser;
			address_s1    <= s_axis_tdata[15:0];
			write_data_s1 <= s_axis_tdata[23:16];
		end
	end

	// decoder
	bsc_decode #(
		.ROM_BANK_BITS(ROM_BANK_BITS),
		.RAM_BANK_BITS(RAM_BANK_BITS)
	) u_decode (
		.req_type       (req_type_s1),
		.address        (address_s1),
		.write_data     (write_data_s1),
		.rom_bank_mask  (rom_bank_mask),
		.enabled        (enabled),
		.rom_bank       (rom_bank),
		.ram_bank       (ram_bank),
		.clock_select   (clock_select),
		.clk_rd_byte    (clk_rd_byte),
		.last_latch_byte(last_latch_byte),
		.res            (res),
		.upd            (upd),
		.rom_bank_d     (rom_bank_d),
		.ram_bank_d     (ram_bank_d)
	);

	// controller registers
	bsc_state #(
		.ROM_BANK_BITS(ROM_BANK_BITS),
		.RAM_BANK_BITS(RAM_BANK_BITS)
	) u_state (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.advance        (advance),
		.upd            (upd),
		.rom_bank_d     (rom_bank_d),
		.ram_bank_d     (ram_bank_d),
		.rom_bank_mask  (rom_bank_mask),
		.enabled        (enabled),
		.rom_bank       (rom_bank),
		.ram_bank       (ram_bank),
		.clock_select   (clock_select),
		.clk_rd_byte    (clk_rd_byte),
		.last_latch_byte(last_latch_byte)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tdata  = {3'b000, out_q.mem_write_data, out_q.read_data, out_q.mem_address};

`ifndef SYNTHESIS
	// the selected ROM bank is never zero
	a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rom_bank != '0)
		else $error("rom bank register holds zero");

	// clock selection stays within the five registers or none
	a_clksel_range: assert property (@(posedge clk) disable iff (!arst_n)
		clock_select <= CLK_SEL_MAX)
		else $error("clock select out of range");

	// a RAM write result only while no clock register is selected
	a_ram_wr_no_clk: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.kind == KIND_RAM_WR) |-> (clock_select == CLK_SEL_NONE))
		else $error("RAM write issued with a clock register selected");

	// a word that moves on shows as a valid result the next cycle
	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_axis_tvalid)
		else $error("advanced word not presented");
`endif

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the cartridge bank controller core
// Bus accesses are fed from a pending queue into the input stream, with
// random gaps on the sending side and random stalls on the receiving side.
// Each accepted access is run through a local copy of the controller
// registers to predict its result word. The prediction is checked field by
// field against the output stream. The ROM bank mask is stepped through
// several settings, 1 and 127 among them, while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;
	import bsc_pkg::*;

	localparam int IDLE_LIMIT      = 500;
	localparam int RANDOM_PER_STEP = 205;
	localparam int MASK_STEP_COUNT = 8;
	localparam logic [6:0] MASK_STEPS [MASK_STEP_COUNT] =
		'{7'd127, 7'd1, 7'd15, 7'd3, 7'd63, 7'd7, 7'd31, 7'd127};

	// one bus access as queued for the driver
	typedef struct packed {
		logic       rw;
		logic [15:0] addr;
		logic [7:0]  data;
	} bus_access_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [6:0]  cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	// accesses waiting to be sent, results waiting to arrive
	bus_access_t pending_access[$];
	bsc_res_t    awaited_words[$];

	// local copy of the controller registers
	logic [6:0] m_mask = 7'd127;
	logic       m_enabled = 1'b0;
	logic [6:0] m_rom_bank = 7'd1;
	logic [1:0] m_ram_bank = 2'd0;
	logic [2:0] m_clk_sel = CLK_SEL_NONE;
	logic [7:0] m_clk_regs [CLK_REGS] = '{default: 8'h00};
	logic       m_latched = 1'b0;
	logic [7:0] m_last_latch = 8'h00;

	bus_access_t tx_word;
	int tx_wait = 0;
	int tx_count = 0;
	bit tx_burst = 1'b0;
	int rx_wait = 0;
	int rx_count = 0;
	bit rx_burst = 1'b0;
	int idle_cycles = 0;
	int mismatches = 0;
	int accesses_taken = 0;
	int results_checked = 0;
	int kind_seen [5] = '{default: 0};

	bank_switch_controller_rtc_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // address[15:0], write_data[23:16]
		.s_axis_tuser  (s_axis_tuser),   // req_type
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // mem_address[20:0], read_data[28:21],
		                                 // mem_write_data[36:29]
		.m_axis_tuser  (m_axis_tuser)    // access_kind
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// apply one access to the local registers and queue the word it yields
	task automatic decode_access(input logic rw, input logic [15:0] a, input logic [7:0] d);
		bsc_res_t   r;
		logic [2:0] region;
		logic [6:0] bank;
		logic [7:0] sel;
		r = '0;
		r.kind = KIND_ABSORB;
		region = a[15:13];
		if (rw == REQ_WRITE) begin
			case (region)
				REG_ENABLE: m_enabled = (d[3:0] == ENABLE_KEY);
				REG_ROM_BANK: begin
					bank = d[6:0] & m_mask;
					m_rom_bank = (bank == 7'd0) ? 7'd1 : bank;
				end
				REG_RAM_SEL: begin
					if (d <= RAM_SEL_MAX) begin
						m_clk_sel = CLK_SEL_NONE;
						m_ram_bank = d[1:0];
					end else if (d >= CLK_CODE_LO && d <= CLK_CODE_HI) begin
						sel = d - CLK_CODE_OFS;
						m_clk_sel = sel[2:0];
					end else begin
						m_clk_sel = CLK_SEL_NONE;
					end
				end
				REG_LATCH: begin
					if (m_last_latch == LATCH_ARM && d == LATCH_FIRE)
						m_latched = ~m_latched;
					m_last_latch = d;
				end
				REG_EXT_RAM: begin
					if (m_clk_sel != CLK_SEL_NONE) begin
						m_clk_regs[m_clk_sel - 3'd1] = d;
					end else begin
						r.kind = KIND_RAM_WR;
						r.mem_address = ADDR_W'({m_ram_bank, a[12:0]});
						r.mem_write_data = d;
					end
				end
				default: ;
			endcase
		end else if (region <= REG_ROM_BANK) begin
			r.kind = KIND_ROM_RD;
			r.mem_address = ADDR_W'(a);
		end else if (region <= REG_LATCH) begin
			r.kind = KIND_ROM_RD;
			r.mem_address = {m_rom_bank, a[13:0]};
		end else if (region != REG_EXT_RAM || !m_enabled) begin
			r.kind = KIND_DIRECT;
			r.read_data = OPEN_BUS;
		end else if (m_clk_sel != CLK_SEL_NONE) begin
			r.kind = KIND_DIRECT;
			r.read_data = m_clk_regs[m_clk_sel - 3'd1];
		end else begin
			r.kind = KIND_RAM_RD;
			r.mem_address = ADDR_W'({m_ram_bank, a[12:0]});
		end
		awaited_words.push_back(r);
	endtask

	task automatic compare_field(input string label, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, label, want, got);
			mismatches++;
		end
	endtask

	task automatic push_access(input logic rw, input logic [15:0] a, input logic [7:0] d);
		bus_access_t acc;
		acc.rw = rw;
		acc.addr = a;
		acc.data = d;
		pending_access.push_back(acc);
	endtask

	// address edges, every region, bank and clock select cases, latch and enable
	task automatic queue_directed_accesses();
		push_access(REQ_READ,  16'h0000, 8'h00);
		push_access(REQ_READ,  16'h3FFF, 8'hFF);
		push_access(REQ_READ,  16'h4000, 8'h00);
		push_access(REQ_READ,  16'h7FFF, 8'h00);
		push_access(REQ_READ,  16'h8000, 8'h00);
		push_access(REQ_READ,  16'hA000, 8'h00);
		push_access(REQ_READ,  16'hFFFF, 8'h00);
		push_access(REQ_WRITE, 16'h9FFF, 8'h12);
		push_access(REQ_WRITE, 16'hC000, 8'h34);
		push_access(REQ_WRITE, 16'h0000, 8'h0A);
		push_access(REQ_WRITE, 16'h2000, 8'h00);
		push_access(REQ_WRITE, 16'h3FFF, 8'hFF);
		push_access(REQ_READ,  16'h7FFF, 8'h00);
		push_access(REQ_WRITE, 16'h4000, 8'h03);
		push_access(REQ_READ,  16'hA000, 8'h00);
		push_access(REQ_WRITE, 16'hBFFF, 8'h55);
		push_access(REQ_WRITE, 16'h5FFF, 8'h08);
		push_access(REQ_WRITE, 16'hA123, 8'hAB);
		push_access(REQ_READ,  16'hBFFF, 8'h00);
		push_access(REQ_WRITE, 16'h4000, 8'h0C);
		push_access(REQ_WRITE, 16'hA000, 8'h5A);
		push_access(REQ_READ,  16'hA001, 8'h00);
		push_access(REQ_WRITE, 16'h4000, 8'h04);
		push_access(REQ_READ,  16'hB000, 8'h00);
		push_access(REQ_WRITE, 16'h6000, 8'h00);
		push_access(REQ_WRITE, 16'h7FFF, 8'h01);
		push_access(REQ_WRITE, 16'h6000, 8'h01);
		push_access(REQ_WRITE, 16'h1FFF, 8'hF0);
		push_access(REQ_READ,  16'hA000, 8'h00);
		push_access(REQ_WRITE, 16'hA000, 8'h77);
		push_access(REQ_WRITE, 16'h0000, 8'hFA);
	endtask

	// mostly control writes and ram window traffic, some fully random noise
	task automatic queue_random_accesses(input int n);
		bus_access_t acc;
		int pick;
		repeat (n) begin
			pick = $urandom_range(0, 15);
			acc.addr = 16'($urandom);
			acc.data = 8'($urandom);
			acc.rw = 1'($urandom);
			case (pick)
				0, 1: begin
					acc.addr[15:13] = REG_ENABLE;
					acc.rw = REQ_WRITE;
					if ($urandom_range(0, 1) == 1)
						acc.data[3:0] = ENABLE_KEY;
				end
				2: begin
					acc.addr[15:13] = REG_ROM_BANK;
					acc.rw = REQ_WRITE;
				end
				3, 4: begin
					acc.addr[15:13] = REG_RAM_SEL;
					acc.rw = REQ_WRITE;
					case ($urandom_range(0, 2))
						0: acc.data = 8'($urandom_range(0, 3));
						1: acc.data = 8'($urandom_range(8, 12));
						default: ;
					endcase
				end
				5: begin
					acc.addr[15:13] = REG_LATCH;
					acc.rw = REQ_WRITE;
					if ($urandom_range(0, 3) != 0)
						acc.data = 8'($urandom_range(0, 1));
				end
				6, 7, 8, 9, 10: acc.addr[15:13] = REG_EXT_RAM;
				11, 12, 13: begin
					acc.addr[15] = 1'b0;
					acc.rw = REQ_READ;
				end
				default: ;
			endcase
			pending_access.push_back(acc);
		end
	endtask

	// driver: one access word per handshake, random gap before each
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_access(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16]);
				accesses_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_wait > 0) begin
					s_axis_tvalid <= 1'b0;
					tx_wait--;
				end else if (pending_access.size() != 0) begin
					tx_word = pending_access.pop_front();
					s_axis_tdata <= {tx_word.data, tx_word.addr};
					s_axis_tuser <= tx_word.rw;
					s_axis_tvalid <= 1'b1;
					if (tx_count % 64 == 0)
						tx_burst = ($urandom_range(0, 3) == 0);
					tx_count++;
					tx_wait = tx_burst ? 0 : $urandom_range(0, 3);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_words.size() == 0) begin
					$display("%0t: result word with none expected, kind %0d data %0h",
						$time, m_axis_tuser, m_axis_tdata);
					mismatches++;
				end else begin
					compare_field("access_kind", awaited_words[0].kind, m_axis_tuser);
					compare_field("mem_address", awaited_words[0].mem_address,
						m_axis_tdata[20:0]);
					compare_field("read_data", awaited_words[0].read_data,
						m_axis_tdata[28:21]);
					compare_field("mem_write_data", awaited_words[0].mem_write_data,
						m_axis_tdata[36:29]);
					void'(awaited_words.pop_front());
					results_checked++;
				end
				if (m_axis_tuser < 3'd5)
					kind_seen[m_axis_tuser]++;
				if (rx_count % 64 == 0)
					rx_burst = ($urandom_range(0, 3) == 0);
				rx_count++;
				rx_wait = rx_burst ? 0 : $urandom_range(0, 3);
			end
			if (rx_wait > 0) begin
				m_axis_tready <= 1'b0;
				rx_wait--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	// sequencing: reset, then one mask setting per phase
	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int p = 0; p < MASK_STEP_COUNT; p++) begin
			while (pending_access.size() != 0 || s_axis_tvalid || awaited_words.size() != 0)
				@(negedge clk);
			repeat (4) @(negedge clk);
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_wdata <= MASK_STEPS[p];
			m_mask = MASK_STEPS[p];
			@(posedge clk);
			cfg_we <= 1'b0;
			@(negedge clk);
			if (p == 0)
				queue_directed_accesses();
			queue_random_accesses(RANDOM_PER_STEP);
		end
		while (pending_access.size() != 0 || s_axis_tvalid || awaited_words.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (awaited_words.size() != 0) begin
			$display("%0t: %0d result words never arrived", $time, awaited_words.size());
			mismatches++;
		end
		$display("ran %0d bus accesses over %0d mask settings, %0d result words checked",
			accesses_taken, MASK_STEP_COUNT, results_checked);
		$display("kinds seen: rom rd %0d, ram rd %0d, ram wr %0d, direct %0d, absorbed %0d",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
